### rtl/core/idec_pkg.sv
// Shared types, codes and decode functions for the MSP430 instruction decoder.
// No dependencies; imported by every module of the decoder.
`timescale 1ns / 1ps

package idec_pkg;

  localparam logic [1:0] CLS_INVALID = 2'd0;
  localparam logic [1:0] CLS_SINGLE  = 2'd1;
  localparam logic [1:0] CLS_DOUBLE  = 2'd2;
  localparam logic [1:0] CLS_JUMP    = 2'd3;

  localparam logic [3:0] K_NONE  = 4'd0;
  localparam logic [3:0] K_REG   = 4'd1;
  localparam logic [3:0] K_IDX   = 4'd2;
  localparam logic [3:0] K_SYM   = 4'd3;
  localparam logic [3:0] K_ABS   = 4'd4;
  localparam logic [3:0] K_IND   = 4'd5;
  localparam logic [3:0] K_AINC  = 4'd6;
  localparam logic [3:0] K_IMM   = 4'd7;
  localparam logic [3:0] K_CONST = 4'd8;

  localparam logic [1:0] AS_REG = 2'd0;
  localparam logic [1:0] AS_IDX = 2'd1;
  localparam logic [1:0] AS_IND = 2'd2;
  localparam logic [1:0] AS_INC = 2'd3;

  localparam logic [3:0] REG_PC = 4'd0;
  localparam logic [3:0] REG_SP = 4'd1;
  localparam logic [3:0] REG_SR = 4'd2;
  localparam logic [3:0] REG_CG = 4'd3;

  localparam logic [3:0] TOP_NONE   = 4'd0;
  localparam logic [3:0] TOP_SINGLE = 4'd1;
  localparam logic [3:0] TOP_JMP_LO = 4'd2;
  localparam logic [3:0] TOP_JMP_HI = 4'd3;

  localparam logic [3:0] OP_RETI = 4'd6;
  localparam logic [3:0] OP_MOV  = 4'd4;
  localparam logic [3:0] OP_ADD  = 4'd5;
  localparam logic [3:0] OP_ADDC = 4'd6;
  localparam logic [3:0] OP_SUBC = 4'd7;
  localparam logic [3:0] OP_SUB  = 4'd8;
  localparam logic [3:0] OP_CMP  = 4'd9;
  localparam logic [3:0] OP_DADD = 4'd10;
  localparam logic [3:0] OP_BIC  = 4'd12;
  localparam logic [3:0] OP_BIS  = 4'd13;
  localparam logic [3:0] OP_XOR  = 4'd14;

  // Highest legal value of word[11:7] for the single-operand group.
  localparam logic [4:0] SINGLE_MAX = 5'd6;

  localparam logic [2:0] AVAIL_ONE_WORD = 3'd2;
  localparam logic [2:0] AVAIL_TWO_WORD = 3'd4;
  localparam logic [2:0] AVAIL_THR_WORD = 3'd6;

  localparam logic [2:0] LEN_NONE = 3'd0;
  localparam logic [2:0] LEN_ONE  = 3'd2;
  localparam logic [2:0] LEN_TWO  = 3'd4;
  localparam logic [2:0] LEN_THR  = 3'd6;

  localparam logic [15:0] CG_ZERO  = 16'h0000;
  localparam logic [15:0] CG_ONE   = 16'h0001;
  localparam logic [15:0] CG_TWO   = 16'h0002;
  localparam logic [15:0] CG_FOUR  = 16'h0004;
  localparam logic [15:0] CG_EIGHT = 16'h0008;
  localparam logic [15:0] CG_MONE  = 16'hFFFF;

  localparam logic [11:0] JUMP_BIAS = 12'd2;

  localparam logic [4:0] AL_NONE = 5'd0;
  localparam logic [4:0] AL_ADC  = 5'd1;
  localparam logic [4:0] AL_NOP  = 5'd2;
  localparam logic [4:0] AL_CLR  = 5'd3;
  localparam logic [4:0] AL_RET  = 5'd4;
  localparam logic [4:0] AL_POP  = 5'd5;
  localparam logic [4:0] AL_BR   = 5'd6;
  localparam logic [4:0] AL_CLRN = 5'd7;
  localparam logic [4:0] AL_CLRZ = 5'd8;
  localparam logic [4:0] AL_DINT = 5'd9;
  localparam logic [4:0] AL_EINT = 5'd10;
  localparam logic [4:0] AL_DADC = 5'd11;
  localparam logic [4:0] AL_DEC  = 5'd12;
  localparam logic [4:0] AL_DECD = 5'd13;
  localparam logic [4:0] AL_INC  = 5'd14;
  localparam logic [4:0] AL_INCD = 5'd15;
  localparam logic [4:0] AL_INV  = 5'd16;
  localparam logic [4:0] AL_RLA  = 5'd17;
  localparam logic [4:0] AL_RLC  = 5'd18;
  localparam logic [4:0] AL_SBC  = 5'd19;
  localparam logic [4:0] AL_SETC = 5'd20;
  localparam logic [4:0] AL_SETN = 5'd21;
  localparam logic [4:0] AL_SETZ = 5'd22;
  localparam logic [4:0] AL_TST  = 5'd23;

  typedef struct packed {
    logic        valid;
    logic [1:0]  cls;
    logic [3:0]  op;
    logic        byte_op;
    logic        short_in;
    logic        reti;
    logic [1:0]  as_mode;
    logic        ad;
    logic [3:0]  sreg;
    logic [3:0]  dreg;
    logic [9:0]  offset;
    logic [15:0] e1;
    logic [15:0] e2;
  } s1_t;

  typedef struct packed {
    logic        uses_ext;
    logic [3:0]  kind;
    logic [15:0] val;
  } src_dec_t;

  typedef struct packed {
    logic        valid;
    logic [1:0]  cls;
    logic [3:0]  op;
    logic        byte_op;
    logic        short_in;
    logic        reti;
    logic        ad;
    logic [3:0]  sreg;
    logic [3:0]  dreg;
    src_dec_t    src;
    logic [15:0] e1;
    logic [15:0] e2;
    logic [4:0]  alias_id;
    logic [11:0] jump_offset;
  } s2_t;

  typedef struct packed {
    logic [1:0]  instr_class;
    logic [3:0]  op_code;
    logic        byte_op;
    logic [3:0]  src_kind;
    logic [3:0]  src_reg;
    logic [15:0] src_value;
    logic [3:0]  dst_kind;
    logic [3:0]  dst_reg;
    logic [15:0] dst_value;
    logic [2:0]  length_bytes;
    logic [11:0] jump_offset;
    logic [4:0]  alias_id;
  } res_t;

  function automatic src_dec_t src_mode(input logic [1:0] as_mode, input logic [3:0] rn,
                                        input logic [15:0] ext);
    src_dec_t d;
    d.uses_ext = 1'b0;
    d.kind     = K_REG;
    d.val      = CG_ZERO;
    case (as_mode)
      AS_REG: begin
        d.kind = (rn == REG_CG) ? K_CONST : K_REG;
      end
      AS_IDX: begin
        if (rn == REG_CG) begin
          d.kind = K_CONST;
          d.val  = CG_ONE;
        end else begin
          d.kind     = (rn == REG_PC) ? K_SYM : (rn == REG_SR) ? K_ABS : K_IDX;
          d.val      = ext;
          d.uses_ext = 1'b1;
        end
      end
      AS_IND: begin
        if (rn == REG_SR) begin
          d.kind = K_CONST;
          d.val  = CG_FOUR;
        end else if (rn == REG_CG) begin
          d.kind = K_CONST;
          d.val  = CG_TWO;
        end else begin
          d.kind = K_IND;
        end
      end
      default: begin
        if (rn == REG_SR) begin
          d.kind = K_CONST;
          d.val  = CG_EIGHT;
        end else if (rn == REG_CG) begin
          d.kind = K_CONST;
          d.val  = CG_MONE;
        end else if (rn == REG_PC) begin
          d.kind     = K_IMM;
          d.val      = ext;
          d.uses_ext = 1'b1;
        end else begin
          d.kind = K_AINC;
        end
      end
    endcase
    return d;
  endfunction

  function automatic logic [4:0] alias_of(input logic [3:0] op, input logic [1:0] as_mode,
                                          input logic ad, input logic [3:0] s,
                                          input logic [3:0] d);
    logic sr_dst;
    logic [4:0] al;
    sr_dst = (d == REG_SR) && !ad;
    al     = AL_NONE;
    if (op == OP_ADDC && as_mode == AS_REG && s == REG_CG) al = AL_ADC;
    else if (op == OP_MOV && as_mode == AS_REG && s == REG_CG)
      al = (!ad && d == REG_CG) ? AL_NOP : AL_CLR;
    else if (op == OP_MOV && as_mode == AS_INC && s == REG_SP)
      al = (d == REG_PC) ? AL_RET : AL_POP;
    else if (op == OP_MOV && !ad && d == REG_PC) al = AL_BR;
    else if (op == OP_BIC && as_mode == AS_IND && s == REG_SR && sr_dst) al = AL_CLRN;
    else if (op == OP_BIC && as_mode == AS_IND && s == REG_CG && sr_dst) al = AL_CLRZ;
    else if (op == OP_BIC && as_mode == AS_INC && s == REG_SR && sr_dst) al = AL_DINT;
    else if (op == OP_BIS && as_mode == AS_INC && s == REG_SR && sr_dst) al = AL_EINT;
    else if (op == OP_DADD && as_mode == AS_REG && s == REG_CG) al = AL_DADC;
    else if (op == OP_SUB && as_mode == AS_IDX && s == REG_CG) al = AL_DEC;
    else if (op == OP_SUB && as_mode == AS_IND && s == REG_CG) al = AL_DECD;
    else if (op == OP_ADD && as_mode == AS_IDX && s == REG_CG) al = AL_INC;
    else if (op == OP_ADD && as_mode == AS_IND && s == REG_CG) al = AL_INCD;
    else if (op == OP_XOR && as_mode == AS_INC && s == REG_CG) al = AL_INV;
    else if (op == OP_ADD && s == d) al = AL_RLA;
    else if (op == OP_ADDC && s == d) al = AL_RLC;
    else if (op == OP_SUBC && as_mode == AS_REG && s == REG_CG) al = AL_SBC;
    else if (op == OP_BIS && as_mode == AS_IDX && s == REG_CG && sr_dst) al = AL_SETC;
    else if (op == OP_BIS && as_mode == AS_IND && s == REG_SR && sr_dst) al = AL_SETN;
    else if (op == OP_BIS && as_mode == AS_IND && s == REG_CG && sr_dst) al = AL_SETZ;
    else if (op == OP_CMP && as_mode == AS_REG && s == REG_CG) al = AL_TST;
    return al;
  endfunction

endpackage

### rtl/core/msp430_instruction_decoder_unit.sv
// An accepted word passes the field, operand and output registers in turn before the done strobe.
// Throughput: one transaction per cycle; the pipeline never holds an item back.
// busy is high only while rst is high; a synchronous reset drops all items in flight.
// Results appear for exactly one cycle with done and cannot be stalled.
// Three register stages: field extraction, operand decode, result assembly.
// Top level of the MSP430 instruction decoder; depends on idec_pkg and the idec stages.
`timescale 1ns / 1ps

module msp430_instruction_decoder_unit
  import idec_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [15:0]        instr_word,
  input  logic [15:0]        ext_word_one,
  input  logic [15:0]        ext_word_two,
  input  logic [2:0]         available_bytes,
  output logic               done,
  output logic [1:0]         instr_class,
  output logic [3:0]         op_code,
  output logic               byte_op,
  output logic [3:0]         src_kind,
  output logic [3:0]         src_reg,
  output logic [15:0]        src_value,
  output logic [3:0]         dst_kind,
  output logic [3:0]         dst_reg,
  output logic [15:0]        dst_value,
  output logic [2:0]         length_bytes,
  output logic signed [11:0] jump_offset,
  output logic [4:0]         alias_id
);

  s1_t  s1;
  s2_t  s2;
  res_t res;
  logic take;

  assign busy = rst;
  assign take = start && !busy;

  idec_fields u_fields (
    .clk             (clk),
    .rst             (rst),
    .take            (take),
    .instr_word      (instr_word),
    .ext_word_one    (ext_word_one),
    .ext_word_two    (ext_word_two),
    .available_bytes (available_bytes),
    .s1              (s1)
  );

  idec_operand u_operand (
    .clk (clk),
    .rst (rst),
    .s1  (s1),
    .s2  (s2)
  );

  idec_output u_output (
    .clk  (clk),
    .rst  (rst),
    .s2   (s2),
    .done (done),
    .res  (res)
  );

  assign instr_class  = res.instr_class;
  assign op_code      = res.op_code;
  assign byte_op      = res.byte_op;
  assign src_kind     = res.src_kind;
  assign src_reg      = res.src_reg;
  assign src_value    = res.src_value;
  assign dst_kind     = res.dst_kind;
  assign dst_reg      = res.dst_reg;
  assign dst_value    = res.dst_value;
  assign length_bytes = res.length_bytes;
  assign jump_offset  = signed'(res.jump_offset);
  assign alias_id     = res.alias_id;

`ifndef ASSERT_OFF
  a_done_after_take: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(take, 3))
    else $error("result without a matching transaction");
  a_take_gives_done: assert property (@(posedge clk) disable iff (rst)
    take ##1 !rst ##1 !rst |=> done)
    else $error("transaction lost in the pipeline");
`endif

endmodule

### rtl/core/idec_fields.sv
// Stage one of the decoder: field extraction and instruction classification.
// Depends on idec_pkg.
`timescale 1ns / 1ps

module idec_fields
  import idec_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        take,
  input  logic [15:0] instr_word,
  input  logic [15:0] ext_word_one,
  input  logic [15:0] ext_word_two,
  input  logic [2:0]  available_bytes,
  output s1_t         s1
);

  s1_t s1_next;
  logic [3:0] top;

  assign top = instr_word[15:12];

  always_comb begin
    s1_next          = '0;
    s1_next.valid    = take;
    s1_next.as_mode  = instr_word[5:4];
    s1_next.ad       = instr_word[7];
    s1_next.sreg     = instr_word[11:8];
    s1_next.dreg     = instr_word[3:0];
    s1_next.offset   = instr_word[9:0];
    s1_next.e1       = (available_bytes >= AVAIL_TWO_WORD) ? ext_word_one : CG_ZERO;
    s1_next.e2       = (available_bytes >= AVAIL_THR_WORD) ? ext_word_two : CG_ZERO;
    s1_next.short_in = available_bytes < AVAIL_ONE_WORD;
    s1_next.cls      = CLS_INVALID;
    if (!s1_next.short_in) begin
      if (top == TOP_NONE) begin
        s1_next.cls = CLS_INVALID;
      end else if (top == TOP_SINGLE) begin
        if (instr_word[11:7] <= SINGLE_MAX) begin
          s1_next.cls     = CLS_SINGLE;
          s1_next.op      = {1'b0, instr_word[9:7]};
          s1_next.byte_op = instr_word[6];
          s1_next.reti    = {1'b0, instr_word[9:7]} == OP_RETI;
        end
      end else if (top == TOP_JMP_LO || top == TOP_JMP_HI) begin
        s1_next.cls = CLS_JUMP;
        s1_next.op  = {1'b0, instr_word[12:10]};
      end else begin
        s1_next.cls     = CLS_DOUBLE;
        s1_next.op      = top;
        s1_next.byte_op = instr_word[6];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1 <= '0;
    end else begin
      s1 <= s1_next;
    end
  end

endmodule

### rtl/core/idec_operand.sv
// Stage two of the decoder: source operand mode, alias lookup and jump offset.
// Depends on idec_pkg.
`timescale 1ns / 1ps

module idec_operand
  import idec_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  s1_t  s1,
  output s2_t  s2
);

  s2_t s2_next;
  logic [3:0] src_rn;

  assign src_rn = (s1.cls == CLS_SINGLE) ? s1.dreg : s1.sreg;

  always_comb begin
    s2_next             = '0;
    s2_next.valid       = s1.valid;
    s2_next.cls         = s1.cls;
    s2_next.op          = s1.op;
    s2_next.byte_op     = s1.byte_op;
    s2_next.short_in    = s1.short_in;
    s2_next.reti        = s1.reti;
    s2_next.ad          = s1.ad;
    s2_next.sreg        = s1.sreg;
    s2_next.dreg        = s1.dreg;
    s2_next.e1          = s1.e1;
    s2_next.e2          = s1.e2;
    s2_next.src         = src_mode(s1.as_mode, src_rn, s1.e1);
    s2_next.alias_id    = alias_of(s1.op, s1.as_mode, s1.ad, s1.sreg, s1.dreg);
    s2_next.jump_offset = {s1.offset[9], s1.offset, 1'b0} + JUMP_BIAS;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2 <= '0;
    end else begin
      s2 <= s2_next;
    end
  end

endmodule

### rtl/core/idec_output.sv
// Stage three of the decoder: result assembly per class and the output register.
// Depends on idec_pkg.
`timescale 1ns / 1ps

module idec_output
  import idec_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  s2_t  s2,
  output logic done,
  output res_t res
);

  res_t res_next;

  always_comb begin
    res_next = '0;
    case (s2.cls)
      CLS_SINGLE: begin
        res_next.instr_class  = CLS_SINGLE;
        res_next.op_code      = s2.op;
        res_next.byte_op      = s2.byte_op;
        res_next.length_bytes = LEN_ONE;
        if (!s2.reti) begin
          res_next.src_kind     = s2.src.kind;
          res_next.src_reg      = s2.dreg;
          res_next.src_value    = s2.src.val;
          res_next.length_bytes = s2.src.uses_ext ? LEN_TWO : LEN_ONE;
        end
      end
      CLS_JUMP: begin
        res_next.instr_class  = CLS_JUMP;
        res_next.op_code      = s2.op;
        res_next.length_bytes = LEN_ONE;
        res_next.jump_offset  = s2.jump_offset;
      end
      CLS_DOUBLE: begin
        res_next.instr_class  = CLS_DOUBLE;
        res_next.op_code      = s2.op;
        res_next.byte_op      = s2.byte_op;
        res_next.src_kind     = s2.src.kind;
        res_next.src_reg      = s2.sreg;
        res_next.src_value    = s2.src.val;
        res_next.dst_reg      = s2.dreg;
        res_next.alias_id     = s2.alias_id;
        if (!s2.ad) begin
          res_next.dst_kind     = K_REG;
          res_next.length_bytes = s2.src.uses_ext ? LEN_TWO : LEN_ONE;
        end else begin
          res_next.dst_kind     = (s2.dreg == REG_PC) ? K_SYM :
                                  (s2.dreg == REG_SR) ? K_ABS : K_IDX;
          res_next.dst_value    = s2.src.uses_ext ? s2.e2 : s2.e1;
          res_next.length_bytes = s2.src.uses_ext ? LEN_THR : LEN_TWO;
        end
        if (s2.alias_id == AL_RET) begin
          res_next.instr_class = CLS_SINGLE;
          res_next.op_code     = OP_RETI;
        end
      end
      default: begin
        res_next.length_bytes = s2.short_in ? LEN_NONE : LEN_ONE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= s2.valid;
    end
  end

  always_ff @(posedge clk) begin
    res <= res_next;
  end

`ifndef ASSERT_OFF
  a_invalid_clean: assert property (@(posedge clk) disable iff (rst)
    done && res.instr_class == CLS_INVALID |->
      res.src_kind == K_NONE && res.dst_kind == K_NONE && res.alias_id == AL_NONE &&
      (res.length_bytes == LEN_NONE || res.length_bytes == LEN_ONE))
    else $error("invalid result carries operand data");
  a_offset_jump_only: assert property (@(posedge clk) disable iff (rst)
    done && res.instr_class != CLS_JUMP |-> res.jump_offset == '0)
    else $error("jump offset on a non-jump result");
  a_zero_len_invalid: assert property (@(posedge clk) disable iff (rst)
    done && res.length_bytes == LEN_NONE |-> res.instr_class == CLS_INVALID)
    else $error("zero length on a valid instruction");
  a_jump_no_operands: assert property (@(posedge clk) disable iff (rst)
    done && res.instr_class == CLS_JUMP |->
      res.src_kind == K_NONE && res.dst_kind == K_NONE && res.length_bytes == LEN_ONE)
    else $error("jump result carries operands");
`endif

endmodule
